>>> src/crcpr_pkg.sv
// Shared types, codes and the CRC-16/CCITT-FALSE byte step for the packet receiver.
`default_nettype none

package crcpr_pkg;

    localparam int unsigned PLEN_W = 6;

    typedef logic [7:0]        t_byte;
    typedef logic [PLEN_W-1:0] t_plen;
    typedef logic [15:0]       t_crc;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN_LO  = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_CMD     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC_LO  = 3'd5,
        PH_CRC_HI  = 3'd6,
        PH_DUMP    = 3'd7
    } t_phase;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CRC_ERR = 2'd1;
    localparam logic [1:0] ST_LEN_ERR = 2'd2;

    localparam logic [1:0] CFG_START_BYTE = 2'd0;
    localparam logic [1:0] CFG_MIN_LEN    = 2'd1;

    localparam t_byte      START_BYTE_RST = 8'hAA;
    localparam logic [6:0] MIN_LEN_RST    = 7'd6;
    localparam logic [15:0] FRAME_OVERHEAD = 16'd6;

    localparam t_crc CRC_INIT = 16'hFFFF;
    localparam t_crc CRC_POLY = 16'h1021;

    function automatic t_crc crc_step(input t_crc crc, input t_byte b);
        t_crc c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/crc_packet_receiver_core.sv
// Framed packet receiver: start hunt, length check, CRC-16 check, payload buffer and dump.
//
// Input channel: one received byte per word on i_rx_byte, taken when i_in_valid is high
// and o_in_stall is low. Output channel: one result word per cycle on the o_ fields,
// taken when o_out_valid is high and i_out_stall is low. Configuration: i_cfg_index
// selects start byte (0) or minimum packet length (1); writes complete at once.
// A byte that ends a packet or rejects a length gives its result from the output
// register in the cycle after it is taken. On a good packet with payload the buffer is
// read back one entry a cycle, while the output is not stalled, through the registered
// read port: the first result passes through the read register and then the output
// register, results come at one per cycle, and input is held off during the dump.
// Reset returns the parser to the start hunt, empties the output register and loads
// start byte 0xAA and minimum length 6. The buffer is not cleared; only entries
// written for the current packet are read.
// While the receiver stalls a waiting result, o_in_stall is high and the dump pauses.
`default_nettype none

module crc_packet_receiver_core #(
    parameter int unsigned BUFFER_BYTES = 64
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire [7:0]  i_rx_byte,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [1:0] o_status,
    output logic [7:0] o_command,
    output logic [5:0] o_payload_length,
    output logic       o_has_data,
    output logic [7:0] o_payload_byte,
    output logic       o_last,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [1:0]  i_cfg_index,
    input  wire [7:0]  i_cfg_data
);

    localparam int unsigned AW = $clog2(BUFFER_BYTES);

    crcpr_pkg::t_phase r_state, n_state;

    crcpr_pkg::t_byte  r_start_byte;
    logic [6:0]        r_min_len;

    crcpr_pkg::t_byte  r_len_lo, n_len_lo;
    crcpr_pkg::t_plen  r_plen, n_plen;
    crcpr_pkg::t_plen  r_idx, n_idx;
    crcpr_pkg::t_crc   r_crc, n_crc;
    crcpr_pkg::t_byte  r_command, n_command;
    crcpr_pkg::t_byte  r_crc_lo, n_crc_lo;

    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_status, n_status;
    crcpr_pkg::t_byte  r_out_cmd, n_out_cmd;
    crcpr_pkg::t_plen  r_out_plen, n_out_plen;
    logic              r_has_data, n_has_data;
    crcpr_pkg::t_byte  r_out_byte, n_out_byte;
    logic              r_last, n_last;

    logic              w_out_free;
    logic              w_in_acc;
    logic [15:0]       w_total;
    logic              w_len_bad;
    crcpr_pkg::t_plen  w_idx_inc;
    logic              w_idx_end;
    logic              w_crc_ok;
    logic              w_start_hit;

    logic              w_wr_en;
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;
    crcpr_pkg::t_byte  w_rd_data;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state == crcpr_pkg::PH_DUMP) || !w_out_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign w_total   = {i_rx_byte, r_len_lo};
    assign w_len_bad = (w_total < {9'd0, r_min_len}) || (w_total < crcpr_pkg::FRAME_OVERHEAD)
                    || (w_total > 16'(BUFFER_BYTES));
    assign w_idx_inc = r_idx + crcpr_pkg::t_plen'(1);
    assign w_idx_end = (w_idx_inc == r_plen);
    assign w_crc_ok  = ({i_rx_byte, r_crc_lo} == r_crc);
    assign w_start_hit = (i_rx_byte == r_start_byte);

    assign w_wr_en = w_in_acc && (r_state == crcpr_pkg::PH_PAYLOAD);

    crcpr_store #(
        .DEPTH(BUFFER_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_idx[AW-1:0]),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            crcpr_pkg::PH_HUNT: begin
                if (w_in_acc && w_start_hit) begin
                    n_state = crcpr_pkg::PH_LEN_LO;
                end
            end
            crcpr_pkg::PH_LEN_LO: begin
                if (w_in_acc) begin
                    n_state = crcpr_pkg::PH_LEN_HI;
                end
            end
            crcpr_pkg::PH_LEN_HI: begin
                if (w_in_acc) begin
                    n_state = w_len_bad ? crcpr_pkg::PH_HUNT : crcpr_pkg::PH_CMD;
                end
            end
            crcpr_pkg::PH_CMD: begin
                if (w_in_acc) begin
                    n_state = (r_plen == '0) ? crcpr_pkg::PH_CRC_LO : crcpr_pkg::PH_PAYLOAD;
                end
            end
            crcpr_pkg::PH_PAYLOAD: begin
                if (w_in_acc && w_idx_end) begin
                    n_state = crcpr_pkg::PH_CRC_LO;
                end
            end
            crcpr_pkg::PH_CRC_LO: begin
                if (w_in_acc) begin
                    n_state = crcpr_pkg::PH_CRC_HI;
                end
            end
            crcpr_pkg::PH_CRC_HI: begin
                if (w_in_acc) begin
                    n_state = (w_crc_ok && r_plen != '0) ? crcpr_pkg::PH_DUMP
                                                         : crcpr_pkg::PH_HUNT;
                end
            end
            crcpr_pkg::PH_DUMP: begin
                if (w_out_free && w_idx_end) begin
                    n_state = crcpr_pkg::PH_HUNT;
                end
            end
            default: begin
                n_state = crcpr_pkg::PH_HUNT;
            end
        endcase
    end

    always_comb begin
        n_len_lo   = r_len_lo;
        n_plen     = r_plen;
        n_idx      = r_idx;
        n_crc      = r_crc;
        n_command  = r_command;
        n_crc_lo   = r_crc_lo;
        n_out_valid = r_out_valid && i_out_stall;
        n_status   = r_status;
        n_out_cmd  = r_out_cmd;
        n_out_plen = r_out_plen;
        n_has_data = r_has_data;
        n_out_byte = r_out_byte;
        n_last     = r_last;
        w_rd_en    = 1'b0;
        w_rd_addr  = w_idx_inc[AW-1:0];
        case (r_state)
            crcpr_pkg::PH_HUNT: begin
                if (w_in_acc && w_start_hit) begin
                    n_crc = crcpr_pkg::CRC_INIT;
                end
            end
            crcpr_pkg::PH_LEN_LO: begin
                if (w_in_acc) begin
                    n_len_lo = i_rx_byte;
                end
            end
            crcpr_pkg::PH_LEN_HI: begin
                if (w_in_acc) begin
                    n_plen = crcpr_pkg::t_plen'(w_total - crcpr_pkg::FRAME_OVERHEAD);
                    if (w_len_bad) begin
                        n_out_valid = 1'b1;
                        n_status    = crcpr_pkg::ST_LEN_ERR;
                        n_out_cmd   = '0;
                        n_out_plen  = '0;
                        n_has_data  = 1'b0;
                        n_out_byte  = '0;
                        n_last      = 1'b1;
                    end
                end
            end
            crcpr_pkg::PH_CMD: begin
                if (w_in_acc) begin
                    n_command = i_rx_byte;
                    n_crc     = crcpr_pkg::crc_step(r_crc, i_rx_byte);
                    n_idx     = '0;
                end
            end
            crcpr_pkg::PH_PAYLOAD: begin
                if (w_in_acc) begin
                    n_crc = crcpr_pkg::crc_step(r_crc, i_rx_byte);
                    n_idx = w_idx_inc;
                end
            end
            crcpr_pkg::PH_CRC_LO: begin
                if (w_in_acc) begin
                    n_crc_lo = i_rx_byte;
                end
            end
            crcpr_pkg::PH_CRC_HI: begin
                if (w_in_acc) begin
                    if (!w_crc_ok) begin
                        n_out_valid = 1'b1;
                        n_status    = crcpr_pkg::ST_CRC_ERR;
                        n_out_cmd   = '0;
                        n_out_plen  = '0;
                        n_has_data  = 1'b0;
                        n_out_byte  = '0;
                        n_last      = 1'b1;
                    end else if (r_plen == '0) begin
                        n_out_valid = 1'b1;
                        n_status    = crcpr_pkg::ST_OK;
                        n_out_cmd   = r_command;
                        n_out_plen  = '0;
                        n_has_data  = 1'b0;
                        n_out_byte  = '0;
                        n_last      = 1'b1;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = '0;
                        n_idx     = '0;
                    end
                end
            end
            crcpr_pkg::PH_DUMP: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = crcpr_pkg::ST_OK;
                    n_out_cmd   = r_command;
                    n_out_plen  = r_plen;
                    n_has_data  = 1'b1;
                    n_out_byte  = w_rd_data;
                    n_last      = w_idx_end;
                    if (!w_idx_end) begin
                        w_rd_en = 1'b1;
                        n_idx   = w_idx_inc;
                    end
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= crcpr_pkg::PH_HUNT;
            r_out_valid  <= 1'b0;
            r_start_byte <= crcpr_pkg::START_BYTE_RST;
            r_min_len    <= crcpr_pkg::MIN_LEN_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    crcpr_pkg::CFG_START_BYTE: r_start_byte <= i_cfg_data;
                    crcpr_pkg::CFG_MIN_LEN:    r_min_len    <= i_cfg_data[6:0];
                    default: begin
                        r_min_len <= r_min_len;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len_lo   <= n_len_lo;
        r_plen     <= n_plen;
        r_idx      <= n_idx;
        r_crc      <= n_crc;
        r_command  <= n_command;
        r_crc_lo   <= n_crc_lo;
        r_status   <= n_status;
        r_out_cmd  <= n_out_cmd;
        r_out_plen <= n_out_plen;
        r_has_data <= n_has_data;
        r_out_byte <= n_out_byte;
        r_last     <= n_last;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_command        = r_out_cmd;
    assign o_payload_length = r_out_plen;
    assign o_has_data       = r_has_data;
    assign o_payload_byte   = r_out_byte;
    assign o_last           = r_last;

endmodule

`default_nettype wire

>>> src/crcpr_store.sv
// Payload buffer: one write port, one enabled read port with registered data.
`default_nettype none

module crcpr_store #(
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  wire                  i_clk,
    input  wire                  i_wr_en,
    input  wire [AW-1:0]         i_wr_addr,
    input  crcpr_pkg::t_byte     i_wr_data,
    input  wire                  i_rd_en,
    input  wire [AW-1:0]         i_rd_addr,
    output crcpr_pkg::t_byte     o_rd_data
);

    crcpr_pkg::t_byte r_mem [DEPTH];
    crcpr_pkg::t_byte r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for crc_packet_receiver_core: byte stream in, result words out.
module tb_top;
    import crcpr_pkg::*;

    localparam int unsigned BUF_BYTES   = 64;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 150;
    localparam int unsigned SETTLE      = 16;
    localparam int unsigned PHASE_BYTES = 12;
    localparam logic [1:0]  CFG_SPARE_A = 2'd2;
    localparam logic [1:0]  CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [1:0] status;
        t_byte      command;
        t_plen      plen;
        logic       has_data;
        t_byte      data;
        logic       last;
    } t_pkt_word;

    typedef enum logic [1:0] {RB_DATA, RB_CRC_LO, RB_CRC_HI} t_row_kind;

    typedef struct packed {
        t_row_kind kind;
        t_byte     value;
        logic      pinned;
        t_pkt_word want;
    } t_dir_row;

    localparam t_pkt_word NO_WORD = '0;
    localparam t_pkt_word LEN_REJECT = '{status: ST_LEN_ERR, command: 8'h00, plen: 6'd0,
                                         has_data: 1'b0, data: 8'h00, last: 1'b1};
    localparam t_pkt_word CRC_REJECT = '{status: ST_CRC_ERR, command: 8'h00, plen: 6'd0,
                                         has_data: 1'b0, data: 8'h00, last: 1'b1};
    localparam t_pkt_word EMPTY_FF   = '{status: ST_OK, command: 8'hFF, plen: 6'd0,
                                         has_data: 1'b0, data: 8'h00, last: 1'b1};

    t_dir_row dir_rows [26] = '{
        '{RB_DATA, 8'hAA, 1'b0, NO_WORD}, '{RB_DATA, 8'h03, 1'b0, NO_WORD},
        '{RB_DATA, 8'h00, 1'b1, LEN_REJECT},
        '{RB_DATA, 8'hAA, 1'b0, NO_WORD}, '{RB_DATA, 8'h41, 1'b0, NO_WORD},
        '{RB_DATA, 8'h00, 1'b1, LEN_REJECT},
        '{RB_DATA, 8'hAA, 1'b0, NO_WORD}, '{RB_DATA, 8'h06, 1'b0, NO_WORD},
        '{RB_DATA, 8'h00, 1'b0, NO_WORD}, '{RB_DATA, 8'h00, 1'b0, NO_WORD},
        '{RB_DATA, 8'h00, 1'b0, NO_WORD}, '{RB_DATA, 8'h00, 1'b1, CRC_REJECT},
        '{RB_DATA, 8'hAA, 1'b0, NO_WORD}, '{RB_DATA, 8'h06, 1'b0, NO_WORD},
        '{RB_DATA, 8'h00, 1'b0, NO_WORD}, '{RB_DATA, 8'hFF, 1'b0, NO_WORD},
        '{RB_CRC_LO, 8'h00, 1'b0, NO_WORD}, '{RB_CRC_HI, 8'h00, 1'b1, EMPTY_FF},
        '{RB_DATA, 8'hAA, 1'b0, NO_WORD}, '{RB_DATA, 8'h08, 1'b0, NO_WORD},
        '{RB_DATA, 8'h00, 1'b0, NO_WORD}, '{RB_DATA, 8'h5A, 1'b0, NO_WORD},
        '{RB_DATA, 8'hAA, 1'b0, NO_WORD}, '{RB_DATA, 8'hFF, 1'b0, NO_WORD},
        '{RB_CRC_LO, 8'h00, 1'b0, NO_WORD}, '{RB_CRC_HI, 8'h00, 1'b0, NO_WORD}
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_rx_byte;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [1:0] o_status;
    logic [7:0] o_command;
    logic [5:0] o_payload_length;
    logic       o_has_data;
    logic [7:0] o_payload_byte;
    logic       o_last;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    t_byte      cfg_start = START_BYTE_RST;
    logic [6:0] cfg_min   = MIN_LEN_RST;

    t_phase      rx_phase     = PH_HUNT;
    logic [15:0] rx_total     = '0;
    logic [6:0]  rx_count     = '0;
    t_crc        rx_crc       = CRC_INIT;
    t_byte       rx_cmd       = '0;
    t_byte       rx_crc_first = '0;
    t_byte       rx_buf [BUF_BYTES];

    t_pkt_word   expected_words [$];
    t_pkt_word   step_words [$];
    int unsigned words_predicted = 0;
    int unsigned bytes_sent = 0;
    int unsigned burst_left = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    bit          hold_req = 1'b0;

    crc_packet_receiver_core #(.BUFFER_BYTES(BUF_BYTES)) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_command        (o_command),
        .o_payload_length (o_payload_length),
        .o_has_data       (o_has_data),
        .o_payload_byte   (o_payload_byte),
        .o_last           (o_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    function automatic t_crc crc16_update(input t_crc crc, input t_byte b);
        t_crc c;
        c = crc ^ {b, 8'h00};
        repeat (8) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic void emit(input logic [1:0] st, input t_byte cmd, input int unsigned plen,
                                 input logic hd, input t_byte pb, input logic lst);
        t_pkt_word w;
        w.status   = st;
        w.command  = cmd;
        w.plen     = t_plen'(plen);
        w.has_data = hd;
        w.data     = pb;
        w.last     = lst;
        step_words.push_back(w);
        words_predicted++;
    endfunction

    function automatic void clear_frame();
        rx_phase = PH_HUNT;
        rx_total = '0;
        rx_count = '0;
        rx_crc   = CRC_INIT;
    endfunction

    function automatic void parse_byte(input t_byte b);
        int unsigned plen;
        int unsigned idx;
        logic        crc_ok;
        plen = (rx_total >= 16'd6) ? int'(rx_total) - 6 : 0;
        case (rx_phase)
            PH_HUNT: begin
                if (b == cfg_start) begin
                    clear_frame();
                    rx_count = 7'd1;
                    rx_phase = PH_LEN_LO;
                end
            end
            PH_LEN_LO: begin
                rx_total = {8'h00, b};
                rx_count = 7'd2;
                rx_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                rx_total[15:8] = b;
                rx_count = 7'd3;
                if (rx_total < {9'd0, cfg_min} || rx_total < 16'd6 || rx_total > BUF_BYTES) begin
                    clear_frame();
                    emit(ST_LEN_ERR, 8'h00, 0, 1'b0, 8'h00, 1'b1);
                end else begin
                    rx_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                rx_cmd   = b;
                rx_crc   = crc16_update(rx_crc, b);
                rx_count = 7'd4;
                rx_phase = (plen == 0) ? PH_CRC_LO : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                idx = int'(rx_count) - 4;
                if (rx_count >= 7'd4 && idx < BUF_BYTES) begin
                    rx_buf[idx] = b;
                end
                rx_crc   = crc16_update(rx_crc, b);
                rx_count = rx_count + 7'd1;
                if (int'(rx_count) >= 4 + plen) begin
                    rx_phase = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                rx_crc_first = b;
                rx_count     = rx_count + 7'd1;
                rx_phase     = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                crc_ok = ({b, rx_crc_first} == rx_crc);
                clear_frame();
                if (!crc_ok) begin
                    emit(ST_CRC_ERR, 8'h00, 0, 1'b0, 8'h00, 1'b1);
                end else if (plen == 0) begin
                    emit(ST_OK, rx_cmd, 0, 1'b0, 8'h00, 1'b1);
                end else begin
                    for (int i = 0; i < plen && i < BUF_BYTES; i++) begin
                        emit(ST_OK, rx_cmd, plen, 1'b1, rx_buf[i], i + 1 == plen);
                    end
                end
            end
            default: begin
                clear_frame();
            end
        endcase
    endfunction

    task automatic send_byte(input t_byte b, input logic pinned = 1'b0,
                             input t_pkt_word pinned_word = '0);
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        bytes_sent++;
        step_words.delete();
        parse_byte(b);
        if (pinned) begin
            expected_words.push_back(pinned_word);
        end else begin
            foreach (step_words[k]) expected_words.push_back(step_words[k]);
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 8);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_words.size() != 0);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input t_byte val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx == CFG_START_BYTE) begin
            cfg_start = val;
        end else if (idx == CFG_MIN_LEN) begin
            cfg_min = val[6:0];
        end
    endtask

    task automatic send_frame();
        int unsigned lo;
        int unsigned plen;
        int unsigned pick;
        logic [15:0] total;
        t_byte       b;
        t_crc        crc;
        lo = (cfg_min > 7'd6) ? int'(cfg_min) - 6 : 0;
        if (lo > 58) lo = 58;
        plen = ($urandom_range(0, 39) == 0) ? 58 : lo + $urandom_range(0, 6);
        if (plen > 58) plen = 58;
        repeat ($urandom_range(0, 2)) begin
            b = t_byte'($urandom);
            if (b == cfg_start) b = ~b;
            send_byte(b);
        end
        pick  = $urandom_range(0, 9);
        total = 16'(plen + 6);
        if (pick == 0) begin
            case ($urandom_range(0, 3))
                0: total = 16'($urandom_range(0, 5));
                1: total = 16'($urandom_range(65, 255));
                2: total = {8'($urandom_range(1, 255)), 8'($urandom)};
                default: total = (cfg_min > 7'd6) ? 16'($urandom_range(6, cfg_min - 1)) : 16'd0;
            endcase
        end
        send_byte(cfg_start);
        send_byte(total[7:0]);
        send_byte(total[15:8]);
        if (pick == 0) return;
        if (pick == 1) begin
            repeat ($urandom_range(0, plen)) send_byte(t_byte'($urandom));
            return;
        end
        b   = t_byte'($urandom);
        crc = crc16_update(CRC_INIT, b);
        send_byte(b);
        repeat (plen) begin
            b   = t_byte'($urandom);
            crc = crc16_update(crc, b);
            send_byte(b);
        end
        if (pick == 2) crc = crc ^ 16'($urandom_range(1, 65535));
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_pkt_word want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                $display("%0t: result word with none expected, expected none, got status %0h",
                         $time, o_status);
            end else begin
                want = expected_words.pop_front();
                check_field("status", want.status, o_status);
                check_field("command", want.command, o_command);
                check_field("payload_length", want.plen, o_payload_length);
                check_field("has_data", want.has_data, o_has_data);
                check_field("payload_byte", want.data, o_payload_byte);
                check_field("last", want.last, o_last);
            end
        end
    end

    initial begin
        int unsigned n;
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        i_out_stall <= 1'b0;
                        n = $urandom_range(10, 30);
                    end
                    1, 2: begin
                        i_out_stall <= ($urandom_range(0, 2) == 0);
                        n = 1;
                    end
                    default: begin
                        i_out_stall <= 1'b1;
                        n = $urandom_range(1, 3);
                    end
                endcase
                repeat (n) @(posedge i_clk);
            end
        end
    end

    initial begin
        t_byte       b;
        t_byte       st;
        t_byte       mn;
        int unsigned mark;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_rx_byte   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                RB_CRC_LO: b = rx_crc[7:0];
                RB_CRC_HI: b = rx_crc[15:8];
                default:   b = dir_rows[i].value;
            endcase
            send_byte(b, dir_rows[i].pinned, dir_rows[i].want);
        end
        drain();
        repeat (SETTLE) @(posedge i_clk);

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin st = 8'h00; mn = 8'h00; end
                1: begin st = 8'hFF; mn = 8'd64; end
                2: begin st = t_byte'($urandom); mn = 8'($urandom_range(6, 24)); end
                3: begin st = t_byte'($urandom); mn = 8'hFF; end
                default: begin st = START_BYTE_RST; mn = {1'b0, MIN_LEN_RST}; end
            endcase
            cfg_write(CFG_START_BYTE, st);
            cfg_write(CFG_MIN_LEN, mn);
            if (p == 0) begin
                cfg_write(CFG_SPARE_A, t_byte'($urandom));
                cfg_write(CFG_SPARE_B, t_byte'($urandom));
            end
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
            if (p == 2) hold_req = 1'b1;
            mark = bytes_sent;
            while (bytes_sent - mark < PHASE_BYTES || (p == 4 && words_predicted < 60)) begin
                send_frame();
                if ($urandom_range(0, 7) == 0) drain();
            end
            drain();
            repeat (SETTLE) @(posedge i_clk);
        end

        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
